[hw/rtl/ledsu_pkg.sv]
// Package for the LED driver serial update block: payload structs, command codes,
// microcode word format, program ROM and the seven-segment font.
// No dependencies.
`default_nettype none

package ledsu_pkg;

  typedef enum logic [1:0] {
    CMD_GLYPH = 2'd0,
    CMD_RAW   = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DISPLAY_MODE = 2'd0,
    REG_DATA_MODE    = 2'd1,
    REG_BRIGHTNESS   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    STEP_MODE = 3'd0,
    STEP_DATA = 3'd1,
    STEP_ADDR = 3'd2,
    STEP_SEG  = 3'd3,
    STEP_CTRL = 3'd4,
    STEP_OFF  = 3'd5
  } step_e;

  typedef enum logic [2:0] {
    SRC_MODE = 3'd0,
    SRC_DATA = 3'd1,
    SRC_ADDR = 3'd2,
    SRC_SEG  = 3'd3,
    SRC_CTRL = 3'd4,
    SRC_OFF  = 3'd5
  } src_e;

  localparam logic [7:0] DataCmdBase = 8'h40;
  localparam logic [7:0] AddrCmdBase = 8'hC0;
  localparam logic [7:0] CtrlCmdBase = 8'h88;
  localparam logic [7:0] OffCmd      = 8'h80;
  localparam int unsigned FontSize   = 24;
  localparam int unsigned CfgWidth   = 3;

  localparam logic [1:0] DisplayModeRst = 2'd2;
  localparam logic [2:0] DataModeRst    = 3'd4;
  localparam logic [2:0] BrightnessRst  = 3'd7;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] digit;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic serial_bit;
    logic frame_start;
    logic frame_end;
    logic last;
  } out_t;

  typedef struct packed {
    src_e src;
    logic starts;
    logic ends;
    logic last;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   advance;
    logic [2:0] bit_idx;
    ucode_t uw;
  } seq_ctrl_t;

  function automatic ucode_t ucode_rom(step_e step);
    ucode_t uw;
    unique case (step)
      STEP_MODE: uw = '{src: SRC_MODE, starts: 1'b1, ends: 1'b1, last: 1'b0};
      STEP_DATA: uw = '{src: SRC_DATA, starts: 1'b1, ends: 1'b1, last: 1'b0};
      STEP_ADDR: uw = '{src: SRC_ADDR, starts: 1'b1, ends: 1'b0, last: 1'b0};
      STEP_SEG:  uw = '{src: SRC_SEG,  starts: 1'b0, ends: 1'b1, last: 1'b0};
      STEP_CTRL: uw = '{src: SRC_CTRL, starts: 1'b1, ends: 1'b1, last: 1'b1};
      STEP_OFF:  uw = '{src: SRC_OFF,  starts: 1'b1, ends: 1'b1, last: 1'b1};
      default:   uw = '{src: SRC_OFF,  starts: 1'b1, ends: 1'b1, last: 1'b1};
    endcase
    return uw;
  endfunction

  function automatic logic [7:0] seg_lookup(logic [7:0] idx);
    logic [7:0] code;
    case (idx)
      8'd0:    code = 8'h3F;
      8'd1:    code = 8'h06;
      8'd2:    code = 8'h5B;
      8'd3:    code = 8'h4F;
      8'd4:    code = 8'h66;
      8'd5:    code = 8'h6D;
      8'd6:    code = 8'h7D;
      8'd7:    code = 8'h07;
      8'd8:    code = 8'h7F;
      8'd9:    code = 8'h6F;
      8'd10:   code = 8'h77;
      8'd11:   code = 8'h7C;
      8'd12:   code = 8'h39;
      8'd13:   code = 8'h5E;
      8'd14:   code = 8'h79;
      8'd15:   code = 8'h71;
      8'd16:   code = 8'h73;
      8'd17:   code = 8'h3E;
      8'd18:   code = 8'h76;
      8'd19:   code = 8'h38;
      8'd20:   code = 8'h80;
      8'd21:   code = 8'h40;
      8'd22:   code = 8'hFF;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ledsu_seq.sv]
// Microcode sequencer: step counter, bit counter and program ROM lookup.
// Depends on ledsu_pkg.
`default_nettype none

module ledsu_seq
  import ledsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [1:0] in_command_i,
  input  logic      out_free_i,
  output logic      in_stall_o,
  output seq_ctrl_t ctrl_o
);

  logic       busy_q, busy_d;
  step_e      step_q, step_d;
  logic [2:0] bit_q, bit_d;
  logic       accept;
  logic       advance;
  logic       byte_done;
  ucode_t     uw;

  assign uw         = ucode_rom(step_q);
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign advance    = busy_q && out_free_i;
  assign byte_done  = advance && (bit_q == 3'd7);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    bit_d  = bit_q;
    if (accept) begin
      busy_d = (cmd_e'(in_command_i) != CMD_NONE);
      step_d = (cmd_e'(in_command_i) == CMD_OFF) ? STEP_OFF : STEP_MODE;
      bit_d  = 3'd0;
    end else if (advance) begin
      bit_d = bit_q + 3'd1;
      if (byte_done) begin
        if (uw.last) begin
          busy_d = 1'b0;
        end else begin
          step_d = step_e'(step_q + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_MODE;
      bit_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      bit_q  <= bit_d;
    end
  end

  assign ctrl_o = '{load: accept, advance: advance, bit_idx: bit_q, uw: uw};

`ifndef SYNTHESIS
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_done && uw.last |=> !busy_q)
    else $error("sequencer still busy after final bit");
  a_off_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_command_i == CMD_OFF |=> busy_q && step_q == STEP_OFF)
    else $error("off transaction did not jump to off step");
  a_idle_bit0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> bit_q == 3'd0)
    else $error("bit counter not aligned at end of transaction");
`endif

endmodule

`default_nettype wire

[hw/rtl/ledsu_dp.sv]
// Datapath: configuration registers, request fields, byte select and output register.
// Depends on ledsu_pkg.
`default_nettype none

module ledsu_dp
  import ledsu_pkg::*;
#(
  parameter int unsigned GlyphCount = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  in_t                in_data_i,
  input  seq_ctrl_t          ctrl_i,
  input  logic               out_stall_i,
  output logic               out_free_o,
  output logic               out_valid_o,
  output out_t               out_data_o
);

  logic [1:0] display_mode_q;
  logic [2:0] data_mode_q;
  logic [2:0] brightness_q;
  logic [2:0] digit_q;
  logic [7:0] seg_q, seg_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic [7:0] cur_byte;
  logic       last_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_mode_q <= DisplayModeRst;
      data_mode_q    <= DataModeRst;
      brightness_q   <= BrightnessRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DISPLAY_MODE: display_mode_q <= cfg_wdata_i[1:0];
        REG_DATA_MODE:    data_mode_q    <= cfg_wdata_i[2:0];
        REG_BRIGHTNESS:   brightness_q   <= cfg_wdata_i[2:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (cmd_e'(in_data_i.command) == CMD_GLYPH) begin
      if (({1'b0, in_data_i.value} < 9'(GlyphCount)) &&
          ({1'b0, in_data_i.value} < 9'(FontSize))) begin
        seg_d = seg_lookup(in_data_i.value);
      end else begin
        seg_d = 8'h00;
      end
    end else begin
      seg_d = in_data_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      digit_q <= in_data_i.digit;
      seg_q   <= seg_d;
    end
  end

  always_comb begin
    unique case (ctrl_i.uw.src)
      SRC_MODE: cur_byte = {6'd0, display_mode_q};
      SRC_DATA: cur_byte = DataCmdBase | {5'd0, data_mode_q};
      SRC_ADDR: cur_byte = AddrCmdBase | {4'd0, digit_q, 1'b0};
      SRC_SEG:  cur_byte = seg_q;
      SRC_CTRL: cur_byte = CtrlCmdBase | {5'd0, brightness_q};
      SRC_OFF:  cur_byte = OffCmd;
      default:  cur_byte = OffCmd;
    endcase
  end

  assign last_bit   = (ctrl_i.bit_idx == 3'd7);
  assign out_free_o = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctrl_i.advance) begin
      out_valid_d       = 1'b1;
      out_d.serial_bit  = cur_byte[ctrl_i.bit_idx];
      out_d.frame_start = ctrl_i.uw.starts && (ctrl_i.bit_idx == 3'd0);
      out_d.frame_end   = ctrl_i.uw.ends && last_bit;
      out_d.last        = ctrl_i.uw.last && last_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !ctrl_i.advance)
    else $error("held transaction overwritten");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled output changed");
  a_cfg_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && !cfg_we_i |=> $stable(brightness_q))
    else $error("brightness changed without a write");
`endif

endmodule

`default_nettype wire

[hw/rtl/led_driver_serial_update.sv]
// An accepted request sets the busy register; each serial bit is then registered in the output
// register. Glyph and raw requests give 40 bits, off gives 8, one bit per cycle when the
// output is not stalled; a new request is taken the cycle after the last bit leaves the bit
// counter. The microcode step and bit counters set the length of each request.
// Command 3 is taken and dropped.
// Reset (async, active low) clears the sequencer and output valid, and loads register defaults.
`default_nettype none

module led_driver_serial_update
  import ledsu_pkg::*;
#(
  parameter int unsigned GlyphCount = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  seq_ctrl_t ctrl;
  logic      out_free;

  ledsu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .out_free_i   (out_free),
    .in_stall_o   (in_stall_o),
    .ctrl_o       (ctrl)
  );

  ledsu_dp #(
    .GlyphCount (GlyphCount)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[verif/ledsu_stream_checker.sv]
// Checker for the LED driver serial update block: tracks register writes, predicts
// the serial bit stream of each accepted request and compares it with the output.
// Depends on ledsu_pkg for the payload structs and command codes.
module ledsu_stream_checker
  import ledsu_pkg::*;
#(
  parameter int unsigned GlyphCount = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FontEntries = 24;
  localparam logic [7:0] SegFont [FontEntries] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
    8'h73, 8'h3E, 8'h76, 8'h38, 8'h80, 8'h40, 8'hFF, 8'h00
  };
  localparam logic [7:0] DataBase = 8'h40;
  localparam logic [7:0] AddrBase = 8'hC0;
  localparam logic [7:0] CtrlBase = 8'h88;
  localparam logic [7:0] BlankOff = 8'h80;

  logic [1:0] disp_mode;
  logic [2:0] data_bits;
  logic [2:0] bright;
  out_t       expected_bits[$];
  out_t       got;
  out_t       want;

  function automatic logic [7:0] segment_for_glyph(logic [7:0] idx);
    if (idx >= GlyphCount || idx >= FontEntries) return 8'h00;
    return SegFont[idx];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic starts, input logic ends,
                           input logic fin);
    out_t r;
    for (int k = 0; k < 8; k++) begin
      r.serial_bit  = b[k];
      r.frame_start = starts && (k == 0);
      r.frame_end   = ends && (k == 7);
      r.last        = fin && (k == 7);
      expected_bits.push_back(r);
    end
  endtask

  task automatic predict_bitstream(input in_t req);
    logic [7:0] seg;
    logic [3:0] addr;
    case (req.command)
      CMD_OFF: begin
        push_byte(BlankOff, 1'b1, 1'b1, 1'b1);
      end
      CMD_GLYPH, CMD_RAW: begin
        seg  = (req.command == CMD_GLYPH) ? segment_for_glyph(req.value) : req.value;
        addr = {req.digit, 1'b0};
        push_byte({6'd0, disp_mode}, 1'b1, 1'b1, 1'b0);
        push_byte(DataBase | {5'd0, data_bits}, 1'b1, 1'b1, 1'b0);
        push_byte(AddrBase | {4'd0, addr}, 1'b1, 1'b0, 1'b0);
        push_byte(seg, 1'b0, 1'b1, 1'b0);
        push_byte(CtrlBase | {5'd0, bright}, 1'b1, 1'b1, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_mode    = 2'd2;
      data_bits    = 3'd4;
      bright       = 3'd7;
      fail_count_o = 0;
      pending_o    = 0;
      expected_bits.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_bits.size() == 0) begin
          $error("unexpected output transaction: %b", got);
          fail_count_o++;
        end else begin
          want = expected_bits.pop_front();
          if (got.serial_bit !== want.serial_bit) begin
            $error("serial_bit: expected %0b, actual %0b", want.serial_bit, got.serial_bit);
            fail_count_o++;
          end
          if (got.frame_start !== want.frame_start) begin
            $error("frame_start: expected %0b, actual %0b", want.frame_start,
                   got.frame_start);
            fail_count_o++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DISPLAY_MODE: disp_mode = cfg_wdata_i[1:0];
          REG_DATA_MODE:    data_bits = cfg_wdata_i[2:0];
          REG_BRIGHTNESS:   bright    = cfg_wdata_i[2:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_bitstream(in_data_i);
      pending_o = expected_bits.size();
    end
  end

endmodule

[verif/tb_led_driver_serial_update.sv]
// Top of the LED driver serial update testbench: clock, reset, register writes,
// request stimulus with sender/receiver idling, and the verdict.
// Depends on ledsu_pkg, led_driver_serial_update and ledsu_stream_checker.
module tb_led_driver_serial_update;
  import ledsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegUnused  = 2'd3;
  localparam int         Limit      = 400000;
  localparam int         HoldCycles = 300;
  localparam int         QuietGap   = 60;
  localparam int         PerPhase   = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgWidth-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;

  int fail_count;
  int pending;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  logic holding;

  led_driver_serial_update dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  ledsu_stream_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    holding = 1'b0;
    wait (hold_req);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= holding || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_t mk_req(cmd_e c, int d, int v);
    in_t r;
    r.command = c;
    r.digit   = d[2:0];
    r.value   = v[7:0];
    return r;
  endfunction

  function automatic in_t rand_req();
    in_t r;
    int  pick;
    pick      = $urandom_range(99);
    r.command = (pick < 40) ? CMD_GLYPH : (pick < 75) ? CMD_RAW :
                (pick < 92) ? CMD_OFF : CMD_NONE;
    r.digit   = 3'($urandom_range(7));
    r.value   = (r.command == CMD_GLYPH && $urandom_range(3) != 0) ?
                8'($urandom_range(27)) : 8'($urandom_range(255));
    return r;
  endfunction

  task automatic send_req(input in_t req);
    logic stalled;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (QuietGap) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgWidth-1:0] dm, input logic [CfgWidth-1:0] dmb,
                            input logic [CfgWidth-1:0] br, input bit junk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DISPLAY_MODE;
    cfg_wdata_i <= dm;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DATA_MODE;
    cfg_wdata_i <= dmb;
    @(posedge clk_i);
    cfg_idx_i   <= REG_BRIGHTNESS;
    cfg_wdata_i <= br;
    @(posedge clk_i);
    if (junk) begin
      cfg_idx_i   <= RegUnused;
      cfg_wdata_i <= CfgWidth'($urandom_range(7));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 73, 0, 26};
    recv_pcts = '{0, 0, 73, 26};
    cycles         = 0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_DISPLAY_MODE;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(mk_req(CMD_GLYPH, 0, 0));
    send_req(mk_req(CMD_GLYPH, 7, 255));
    send_req(mk_req(CMD_GLYPH, 5, 22));
    send_req(mk_req(CMD_GLYPH, 6, 23));
    send_req(mk_req(CMD_GLYPH, 3, 24));
    send_req(mk_req(CMD_GLYPH, 1, 20));
    send_req(mk_req(CMD_RAW, 0, 8'h00));
    send_req(mk_req(CMD_RAW, 7, 8'hFF));
    send_req(mk_req(CMD_RAW, 2, 8'hA5));
    send_req(mk_req(CMD_RAW, 4, 8'h5A));
    send_req(mk_req(CMD_OFF, 7, 255));
    send_req(mk_req(CMD_OFF, 0, 0));
    send_req(mk_req(CMD_NONE, 5, 8'h3C));
    send_req(mk_req(CMD_GLYPH, 2, 9));
    send_req(mk_req(CMD_NONE, 7, 255));
    send_req(mk_req(CMD_OFF, 3, 17));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs(3'h7, 3'h7, 3'h7, 1'b0);
        1: write_regs(3'h0, 3'h0, 3'h0, 1'b0);
        2: write_regs(CfgWidth'($urandom_range(7)), CfgWidth'($urandom_range(7)),
                      CfgWidth'($urandom_range(7)), 1'b1);
        default: write_regs(3'd2, 3'd4, 3'd7, 1'b1);
      endcase
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      if (ph == 0) begin
        hold_req = 1'b1;
        repeat (8) send_req(rand_req());
      end
      repeat (PerPhase) send_req(rand_req());
      drain();
    end

    recv_stall_pct = 0;
    repeat (QuietGap) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
